[design/fmsp_pkg.sv]
// ----------------------------------------------------------------------------
// fmsp_pkg
// Shared types, constants and helpers of the file mode string parser.
// ----------------------------------------------------------------------------
package fmsp_pkg;

    // mode masks
    localparam logic [11:0] MODE_ALL  = 12'o7777;
    localparam logic [8:0]  RWX_ALL   = 9'o777;
    localparam logic [8:0]  USER_BITS = 9'o700;
    localparam logic [8:0]  GRP_BITS  = 9'o070;
    localparam logic [8:0]  OTH_BITS  = 9'o007;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_COMMA = 8'h2c;

    // who class bits
    localparam logic [2:0] WHO_U   = 3'b100;
    localparam logic [2:0] WHO_G   = 3'b010;
    localparam logic [2:0] WHO_O   = 3'b001;
    localparam logic [2:0] WHO_ALL = 3'b111;

    // permission letter bits
    localparam logic [2:0] PERM_R = 3'b100;
    localparam logic [2:0] PERM_W = 3'b010;
    localparam logic [2:0] PERM_X = 3'b001;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_SET = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_WHO  = 2'd0,
        PH_OP   = 2'd1,
        PH_PERM = 2'd2
    } phase_t;

    typedef struct packed {
        logic [11:0] octal_value;
        logic        octal_ok;
        logic        octal_seen_digit;
        logic [11:0] symbolic_mode;
        logic [2:0]  who_classes;
        logic        who_seen;
        op_t         operator_code;
        logic [2:0]  rwx_bits;
        phase_t      clause_phase;
        logic        symbolic_error;
    } parse_state_t;

    typedef struct packed {
        logic [11:0] new_mode;
        logic        status;
        logic        was_octal;
    } result_t;

    // parse state at the start of a string
    function automatic parse_state_t clear_state(input logic [11:0] mode);
        parse_state_t s;
        s.octal_value      = '0;
        s.octal_ok         = 1'b1;
        s.octal_seen_digit = 1'b0;
        s.symbolic_mode    = mode & MODE_ALL;
        s.who_classes      = '0;
        s.who_seen         = 1'b0;
        s.operator_code    = OP_ADD;
        s.rwx_bits         = '0;
        s.clause_phase     = PH_WHO;
        s.symbolic_error   = 1'b0;
        return s;
    endfunction

endpackage

[design/fmsp_step.sv]
// ----------------------------------------------------------------------------
// fmsp_step
// Per-character update of the octal and symbolic readings, and the result
// selection on the terminating NUL.
// ----------------------------------------------------------------------------
module fmsp_step
(
    input  fmsp_pkg::parse_state_t state_in,
    input  logic [7:0]             character,
    input  logic                   start_req,
    input  logic [11:0]            current_mode,
    output fmsp_pkg::parse_state_t state_out,
    output logic                   emit,
    output fmsp_pkg::result_t      result
);
    import fmsp_pkg::*;

    // apply the pending clause to a mode
    function automatic logic [11:0] apply_clause(input parse_state_t s);
        logic [8:0]  who;
        logic [8:0]  perms;
        logic [11:0] m;
        who = s.who_seen ? ({9{s.who_classes[2]}} & USER_BITS)
                         | ({9{s.who_classes[1]}} & GRP_BITS)
                         | ({9{s.who_classes[0]}} & OTH_BITS)
                         : RWX_ALL;
        perms = {(who[8:6] != 3'b000) ? s.rwx_bits : 3'b000,
                 (who[5:3] != 3'b000) ? s.rwx_bits : 3'b000,
                 (who[2:0] != 3'b000) ? s.rwx_bits : 3'b000};
        case (s.operator_code)
            OP_ADD:  m = s.symbolic_mode | {3'b000, perms};
            OP_SUB:  m = s.symbolic_mode & ~{3'b000, perms};
            default: m = (s.symbolic_mode & ~{3'b000, who}) | {3'b000, perms};
        endcase
        return m & MODE_ALL;
    endfunction

    parse_state_t s;
    parse_state_t n;
    logic [14:0]  shifted;
    logic [2:0]   perm_letter;

    // octal accumulation candidate
    assign shifted = {s.octal_value, 3'b000} | {12'd0, character[2:0]};

    always_comb
    begin
        perm_letter = 3'b000;
        case (character)
            CH_R:    perm_letter = PERM_R;
            CH_W:    perm_letter = PERM_W;
            CH_X:    perm_letter = PERM_X;
            default: perm_letter = 3'b000;
        endcase
    end

    always_comb
    begin
        s      = start_req ? clear_state(current_mode) : state_in;
        n      = s;
        emit   = 1'b0;
        result = '0;

        if (character != CH_NUL)
        begin
            // octal reading
            if (s.octal_ok)
            begin
                if (character < CH_ZERO || character > CH_SEVEN)
                begin
                    n.octal_ok = 1'b0;
                end
                else
                begin
                    n.octal_seen_digit = 1'b1;
                    if (shifted > {3'b000, MODE_ALL})
                        n.octal_ok = 1'b0;
                    else
                        n.octal_value = shifted[11:0];
                end
            end

            // symbolic reading
            if (!s.symbolic_error)
            begin
                if (s.clause_phase == PH_WHO)
                begin
                    case (character)
                        CH_U:
                        begin
                            n.who_classes = s.who_classes | WHO_U;
                            n.who_seen    = 1'b1;
                        end
                        CH_G:
                        begin
                            n.who_classes = s.who_classes | WHO_G;
                            n.who_seen    = 1'b1;
                        end
                        CH_O:
                        begin
                            n.who_classes = s.who_classes | WHO_O;
                            n.who_seen    = 1'b1;
                        end
                        CH_A:
                        begin
                            n.who_classes = WHO_ALL;
                            n.who_seen    = 1'b1;
                        end
                        CH_PLUS:
                        begin
                            n.operator_code = OP_ADD;
                            n.clause_phase  = PH_OP;
                        end
                        CH_MINUS:
                        begin
                            n.operator_code = OP_SUB;
                            n.clause_phase  = PH_OP;
                        end
                        CH_EQ:
                        begin
                            n.operator_code = OP_SET;
                            n.clause_phase  = PH_OP;
                        end
                        default: n.symbolic_error = 1'b1;
                    endcase
                end
                else if (perm_letter != 3'b000)
                begin
                    n.rwx_bits     = s.rwx_bits | perm_letter;
                    n.clause_phase = PH_PERM;
                end
                else if (character == CH_COMMA && s.clause_phase == PH_PERM)
                begin
                    n.symbolic_mode = apply_clause(s);
                    n.who_classes   = '0;
                    n.who_seen      = 1'b0;
                    n.operator_code = OP_ADD;
                    n.rwx_bits      = '0;
                    n.clause_phase  = PH_WHO;
                end
                else
                begin
                    n.symbolic_error = 1'b1;
                end
            end
        end
        else
        begin
            // end of string: close the last clause and pick the result
            emit = 1'b1;
            if (s.octal_ok && s.octal_seen_digit)
            begin
                result.new_mode  = s.octal_value & MODE_ALL;
                result.status    = 1'b0;
                result.was_octal = 1'b1;
            end
            else if (s.symbolic_error
                     || s.clause_phase == PH_OP
                     || (s.clause_phase == PH_WHO && s.who_seen))
            begin
                result.new_mode  = '0;
                result.status    = 1'b1;
                result.was_octal = 1'b0;
            end
            else
            begin
                result.new_mode  = (s.clause_phase == PH_PERM) ? apply_clause(s)
                                                               : s.symbolic_mode;
                result.status    = 1'b0;
                result.was_octal = 1'b0;
            end
            n = clear_state(12'd0);
        end
    end

    assign state_out = n;

endmodule

[design/file_mode_string_parser.sv]
// ----------------------------------------------------------------------------
// file_mode_string_parser
// Parses a chmod-style mode string, one character per word, in octal and
// symbolic form at once, and gives the resulting mode on the closing NUL.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one character per word with the file's current
//   mode; tuser marks the first character of a string and reloads the
//   parse state from current_mode. A NUL character ends the string and
//   yields one result word on the master side; other characters yield none.
//   Throughput is one character per cycle while s_axis_tready is high: the
//   parse state register is updated by one level of character decode and clause logic per word.
//   The result word of an accepted NUL is registered before it is offered.
//   The result sits in an output register backed by one skid register, so
//   characters keep flowing while a result waits; s_axis_tready drops only
//   when both hold a result the receiver has not yet taken.
//   Reset clears the parse state (mode zero, octal reading armed) and
//   empties both result registers.
// ----------------------------------------------------------------------------
module file_mode_string_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // character[7:0], current_mode[19:8], zero
    input  logic        s_axis_tuser,   // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // new_mode[11:0], zero
    output logic [1:0]  m_axis_tuser    // status[0], was_octal[1]
);
    import fmsp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         emit;
    result_t      step_result;
    logic         out_valid_reg;
    result_t      out_data_reg;
    logic         skid_valid_reg;
    result_t      skid_data_reg;
    logic         in_accept;
    logic         emit_now;
    logic         out_free;

    // per-character update
    fmsp_step u_step
    (
        .state_in     (state_reg),
        .character    (s_axis_tdata[7:0]),
        .start_req    (s_axis_tuser),
        .current_mode (s_axis_tdata[19:8]),
        .state_out    (state_next),
        .emit         (emit),
        .result       (step_result)
    );

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign emit_now      = in_accept && emit;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // parse state and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= clear_state(12'd0);
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= emit_now;
                end
            end
            else if (emit_now)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (emit_now)
                out_data_reg <= step_result;
        end
        else if (emit_now)
        begin
            skid_data_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg.new_mode};
    assign m_axis_tuser  = {out_data_reg.was_octal, out_data_reg.status};

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tdata[7:0] == CH_NUL) |=>
        (state_reg.octal_ok && !state_reg.symbolic_error
         && state_reg.clause_phase == PH_WHO && state_reg.symbolic_mode == 12'd0))
        else $error("parse state not cleared after end of string");

    a_octal_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
        else $error("octal result flagged invalid");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[11:0] == 12'd0))
        else $error("invalid result carries a mode");

    a_no_result_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tdata[7:0] != CH_NUL && !m_axis_tvalid) |=>
        !m_axis_tvalid)
        else $error("result produced by a non-terminating character");

endmodule

[dv/fmsp_checker.sv]
// ----------------------------------------------------------------------------
// fmsp_checker
// Watches both streams of the file mode string parser. Each accepted
// character goes through a local octal and symbolic parse, each closing NUL
// queues the mode it should produce, and each result word is compared field
// by field with the oldest queued mode.
// ----------------------------------------------------------------------------
module fmsp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // character[7:0], current_mode[19:8], zero
    input  logic        s_axis_tuser,   // start_req
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // new_mode[11:0], zero
    input  logic [1:0]  m_axis_tuser,   // status[0], was_octal[1]
    output int          fail_count,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import fmsp_pkg::*;

    // octal reading
    logic [11:0] oct_val;
    logic        oct_ok;
    logic        oct_digit;

    // symbolic reading
    logic [11:0] sym_mode;
    logic [2:0]  who;
    logic        who_any;
    op_t         op;
    logic [2:0]  perm;
    phase_t      phase;
    logic        sym_err;

    // modes still owed by the block, oldest first
    result_t     modes_due[$];

    initial
    begin
        fail_count   = 0;
        results_owed = 0;
    end

    task automatic clear_clause();
        who     = '0;
        who_any = 1'b0;
        op      = OP_ADD;
        perm    = '0;
        phase   = PH_WHO;
    endtask

    task automatic restart_parse(input logic [11:0] mode);
        oct_val   = '0;
        oct_ok    = 1'b1;
        oct_digit = 1'b0;
        sym_mode  = mode & MODE_ALL;
        sym_err   = 1'b0;
        clear_clause();
    endtask

    // fold the finished clause into the symbolic mode
    task automatic apply_clause();
        logic [8:0] who_bits;
        logic [8:0] grant;
        who_bits = who_any ? {{3{who[2]}}, {3{who[1]}}, {3{who[0]}}} : RWX_ALL;
        grant    = who_bits & {3{perm}};
        case (op)
            OP_ADD:  sym_mode = sym_mode | {3'b000, grant};
            OP_SUB:  sym_mode = sym_mode & ~{3'b000, grant};
            default: sym_mode = (sym_mode & ~{3'b000, who_bits}) | {3'b000, grant};
        endcase
        sym_mode = sym_mode & MODE_ALL;
    endtask

    task automatic take_octal(input logic [7:0] c);
        logic [14:0] shifted;
        if (!oct_ok)
            return;
        if (c < CH_ZERO || c > CH_SEVEN)
        begin
            oct_ok = 1'b0;
            return;
        end
        oct_digit = 1'b1;
        shifted   = {oct_val, 3'b000} | {12'b0, c[2:0]};
        if (shifted > {3'b000, MODE_ALL})
            oct_ok = 1'b0;
        else
            oct_val = shifted[11:0];
    endtask

    task automatic take_symbolic(input logic [7:0] c);
        logic [2:0] letter;
        if (sym_err)
            return;
        if (phase == PH_WHO)
        begin
            case (c)
                CH_U:
                begin
                    who     = who | WHO_U;
                    who_any = 1'b1;
                end
                CH_G:
                begin
                    who     = who | WHO_G;
                    who_any = 1'b1;
                end
                CH_O:
                begin
                    who     = who | WHO_O;
                    who_any = 1'b1;
                end
                CH_A:
                begin
                    who     = WHO_ALL;
                    who_any = 1'b1;
                end
                CH_PLUS:
                begin
                    op    = OP_ADD;
                    phase = PH_OP;
                end
                CH_MINUS:
                begin
                    op    = OP_SUB;
                    phase = PH_OP;
                end
                CH_EQ:
                begin
                    op    = OP_SET;
                    phase = PH_OP;
                end
                default: sym_err = 1'b1;
            endcase
            return;
        end
        letter = (c == CH_R) ? PERM_R :
                 (c == CH_W) ? PERM_W :
                 (c == CH_X) ? PERM_X : 3'b000;
        if (letter != 3'b000)
        begin
            perm  = perm | letter;
            phase = PH_PERM;
        end
        else if (c == CH_COMMA && phase == PH_PERM)
        begin
            apply_clause();
            clear_clause();
        end
        else
            sym_err = 1'b1;
    endtask

    // one accepted character word; a NUL queues the mode it yields
    task automatic parse_character(input logic [7:0] c, input logic start,
                                   input logic [11:0] cur);
        result_t r;
        if (start)
            restart_parse(cur);
        if (c != CH_NUL)
        begin
            take_octal(c);
            take_symbolic(c);
            return;
        end
        if (!sym_err)
        begin
            if (phase == PH_PERM)
                apply_clause();
            else if (phase == PH_OP || who_any)
                sym_err = 1'b1;
        end
        if (oct_ok && oct_digit)
        begin
            r.new_mode  = oct_val;
            r.status    = 1'b0;
            r.was_octal = 1'b1;
        end
        else if (sym_err)
        begin
            r.new_mode  = '0;
            r.status    = 1'b1;
            r.was_octal = 1'b0;
        end
        else
        begin
            r.new_mode  = sym_mode;
            r.status    = 1'b0;
            r.was_octal = 1'b0;
        end
        modes_due.push_back(r);
        restart_parse('0);
    endtask

    task automatic check_result();
        result_t want;
        if (modes_due.size() == 0)
        begin
            $display("%0t: unexpected result word: new_mode %o status %0d was_octal %0d",
                     $time, m_axis_tdata[11:0], m_axis_tuser[0], m_axis_tuser[1]);
            fail_count++;
            return;
        end
        want = modes_due.pop_front();
        if (m_axis_tdata[11:0] !== want.new_mode)
        begin
            $display("%0t: new_mode expected %o actual %o",
                     $time, want.new_mode, m_axis_tdata[11:0]);
            fail_count++;
        end
        if (m_axis_tuser[0] !== want.status)
        begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, m_axis_tuser[0]);
            fail_count++;
        end
        if (m_axis_tuser[1] !== want.was_octal)
        begin
            $display("%0t: was_octal expected %0d actual %0d",
                     $time, want.was_octal, m_axis_tuser[1]);
            fail_count++;
        end
    endtask

    // sample both channels at the edge where the words move
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse('0);
            modes_due.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                parse_character(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[19:8]);
        end
        results_owed = modes_due.size();
    end

endmodule

[dv/file_mode_string_parser_tb.sv]
// ----------------------------------------------------------------------------
// file_mode_string_parser_tb
// Drives mode strings into the parser: a few hand-picked strings first, then
// random well-formed symbolic strings, octal numbers, corrupted strings and
// byte noise, with random gaps on both sides and one long receiver stall.
// Checking is done by fmsp_checker.
// ----------------------------------------------------------------------------
module file_mode_string_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmsp_pkg::*;

    localparam int ITEMS       = 1950;
    localparam int CALM_ITEMS  = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          fail_count;
    int          results_owed;
    int          words_sent;
    int          cycles;
    logic        idle_on;
    logic        hold_go;
    logic        hold_done;

    logic [7:0]  who_set [4];
    logic [7:0]  op_set [3];
    logic [7:0]  perm_set [3];
    logic [7:0]  chars[$];

    file_mode_string_parser DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fmsp_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result sink: random stalls plus one long hold-off
    initial
    begin : result_sink
        int hold_left;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                // drop m_axis_tready for a random stall, the loop edge included
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // offer one character word and wait for it to be taken
    task automatic send_word(input logic [7:0] ch, input logic first,
                             input logic [11:0] mode);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, mode, ch};
        s_axis_tuser  <= first;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // text followed by its NUL
    task automatic send_text(input string text, input logic first,
                             input logic [11:0] mode);
        for (int i = 0; i < text.len(); i++)
            send_word(text[i], first && i == 0, mode);
        send_word(CH_NUL, first && text.len() == 0, mode);
    endtask

    // stimulus
    initial
    begin
        int          pick;
        int          pos;
        int          clauses;
        logic        lead_start;
        logic [11:0] mode;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        idle_on       = 1'b1;
        hold_go       = 1'b0;
        words_sent    = 0;
        who_set       = '{CH_U, CH_G, CH_O, CH_A};
        op_set        = '{CH_PLUS, CH_MINUS, CH_EQ};
        perm_set      = '{CH_R, CH_W, CH_X};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // empty string keeps the current mode
        send_text("", 1'b1, 12'o7777);
        // largest octal value, then one past it
        send_text("7777", 1'b1, 12'o0000);
        send_text("10000", 1'b1, 12'o1234);
        // all three operators, bare '=' and a trailing comma
        send_text("u+x,g-w,=r,", 1'b1, 12'o4755);
        // leading comma
        send_text(",", 1'b1, 12'o0777);
        // who letter without operator, no start word
        send_text("u", 1'b0, 12'o0000);

        // long receiver hold-off while empty strings keep coming
        hold_go = 1'b1;
        repeat (24)
            send_word(CH_NUL, 1'b1, 12'($urandom_range(0, 4095)));

        // random strings
        while (words_sent < ITEMS)
        begin
            chars.delete();
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // well-formed symbolic clauses
                clauses = $urandom_range(1, 3);
                for (int i = 0; i < clauses; i++)
                begin
                    if (i > 0)
                        chars.push_back(CH_COMMA);
                    repeat ($urandom_range(0, 3))
                        chars.push_back(who_set[$urandom_range(0, 3)]);
                    chars.push_back(op_set[$urandom_range(0, 2)]);
                    repeat ($urandom_range(1, 3))
                        chars.push_back(perm_set[$urandom_range(0, 2)]);
                end
                if ($urandom_range(0, 3) == 0)
                    chars.push_back(CH_COMMA);
                // broken variant: stray byte, extra comma or a lost character
                if (pick >= 50)
                begin
                    pos = $urandom_range(0, chars.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       chars[pos] = 8'($urandom_range(1, 255));
                        1:       chars.insert(pos, CH_COMMA);
                        default: chars.delete(pos);
                    endcase
                end
            end
            else if (pick < 85)
            begin
                // octal digits, five of them often overflow
                repeat ($urandom_range(1, 5))
                    chars.push_back(CH_ZERO | 8'($urandom_range(0, 7)));
            end
            else
            begin
                // byte noise
                repeat ($urandom_range(0, 6))
                    chars.push_back(8'($urandom_range(1, 255)));
            end
            chars.push_back(CH_NUL);

            idle_on    = (words_sent < ITEMS - CALM_ITEMS) && ($urandom_range(0, 5) != 0);
            lead_start = ($urandom_range(0, 9) != 0);
            mode       = 12'($urandom_range(0, 4095));
            for (int i = 0; i < chars.size(); i++)
                send_word(chars[i], (i == 0) ? lead_start : ($urandom_range(0, 39) == 0),
                          mode);
        end
        s_axis_tvalid <= 1'b0;

        // drain and settle
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
design/fmsp_pkg.sv
design/fmsp_step.sv
design/file_mode_string_parser.sv
dv/fmsp_checker.sv
dv/file_mode_string_parser_tb.sv
